// ----- rtl/core/fp8_e4m3_multiply_assert.svh -----
// assertion macros used by the checker file
`ifndef FP8_E4M3_MULTIPLY_ASSERT_SVH
`define FP8_E4M3_MULTIPLY_ASSERT_SVH

`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/f8m_pkg.sv -----
`default_nettype none
package f8m_pkg;
  localparam logic [7:0] NanCode = 8'h7F;
  localparam logic [7:0] MaxMag  = 8'h7E;
  localparam logic [7:0] SignBit = 8'h80;
  localparam int         ExpTop  = 15;
  localparam int         Bias    = 7;

  typedef struct packed {
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } f8m_req_t;

  typedef struct packed {
    logic [7:0] product;
  } f8m_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/f8m_stream_if.sv -----
`default_nettype none
interface f8m_stream_if #(
  parameter int Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/f8m_unpack.sv -----
`default_nettype none
// decodes one code into a hidden-one significand and a signed biased exponent
module f8m_unpack (
  input  wire logic [7:0] code_i,
  output logic      [3:0] sig_o,
  output logic signed [5:0] exp_o
);
  logic [3:0] e;
  logic [2:0] m;

  assign e = code_i[6:3];
  assign m = code_i[2:0];

  always_comb begin
    if (e != 4'd0) begin
      sig_o = {1'b1, m};
      exp_o = $signed({2'b00, e});
    end else if (m[2]) begin
      sig_o = {m, 1'b0};
      exp_o = 6'sd0;
    end else if (m[1]) begin
      sig_o = {m[1:0], 2'b00};
      exp_o = -6'sd1;
    end else begin
      sig_o = {m[0], 3'b000};
      exp_o = -6'sd2;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/fp8_e4m3_multiply.sv -----
`default_nettype none
// FP8 E4M3FN multiplier. One request can enter every cycle unless the output is stalled.
// There are three register stages: decode, significand multiply, and normalize/round/pack.
// A request passes through all three before its product is valid. A stall on the output
// holds all stages. Nothing is dropped or repeated.
module fp8_e4m3_multiply (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  f8m_stream_if.sink   req_i,
  f8m_stream_if.source rsp_o
);
  import f8m_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q;

  // stage 1: decode
  logic [3:0] sa, sb;
  logic signed [5:0] ea, eb;
  logic [7:0] a, b;
  logic spec1_d;
  logic [7:0] spec1_val_d;

  logic       spec1_q;
  logic [7:0] spec1_val_q;
  logic       sign1_q;
  logic [3:0] sa_q, sb_q;
  logic signed [6:0] er1_q;

  // stage 2: multiply
  logic       spec2_q;
  logic [7:0] spec2_val_q;
  logic       sign2_q;
  logic [7:0] prod2_q;
  logic signed [6:0] er2_q;

  // stage 3 output
  logic [7:0] out_d, out_q;

  assign adv = !v3_q || rsp_o.ready;
  assign req_i.ready = adv;
  assign a = req_i.data[15:8];
  assign b = req_i.data[7:0];

  f8m_unpack u_unpack_a (.code_i(a), .sig_o(sa), .exp_o(ea));
  f8m_unpack u_unpack_b (.code_i(b), .sig_o(sb), .exp_o(eb));

  always_comb begin
    spec1_d = 1'b0;
    spec1_val_d = '0;
    if (a[6:0] == NanCode[6:0] || b[6:0] == NanCode[6:0]) begin
      spec1_d = 1'b1;
      spec1_val_d = NanCode;
    end else if (a[6:0] == 7'd0 || b[6:0] == 7'd0) begin
      spec1_d = 1'b1;
      spec1_val_d = (a ^ b) & SignBit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      spec1_q     <= spec1_d;
      spec1_val_q <= spec1_val_d;
      sign1_q     <= a[7] ^ b[7];
      sa_q        <= sa;
      sb_q        <= sb;
      er1_q       <= 7'(ea) + 7'(eb) - 7'(Bias);
      spec2_q     <= spec1_q;
      spec2_val_q <= spec1_val_q;
      sign2_q     <= sign1_q;
      prod2_q     <= {4'b0000, sa_q} * {4'b0000, sb_q};
      er2_q       <= er1_q;
      out_q       <= out_d;
    end
  end

  // stage 3: normalize, round, pack
  logic signed [6:0] er;
  logic [2:0] mr;
  logic [3:0] mr_inc;
  logic       g, st;

  always_comb begin
    if (prod2_q[7]) begin
      er = er2_q + 7'sd1;
      mr = prod2_q[6:4];
      g  = prod2_q[3];
      st = |prod2_q[2:0];
    end else begin
      er = er2_q;
      mr = prod2_q[5:3];
      g  = prod2_q[2];
      st = |prod2_q[1:0];
    end
    mr_inc = {1'b0, mr} + {3'b000, g & (mr[0] | st)};
    if (mr_inc[3]) begin
      er = er + 7'sd1;
    end
    if (spec2_q) begin
      out_d = spec2_val_q;
    end else if (er > 7'(ExpTop) || (er == 7'(ExpTop) && mr_inc[2:0] == 3'd7)) begin
      out_d = {sign2_q, MaxMag[6:0]};
    end else if (er <= 7'sd0) begin
      out_d = {sign2_q, 7'd0};
    end else begin
      out_d = {sign2_q, er[3:0], mr_inc[2:0]};
    end
  end

  assign rsp_o.valid = v3_q;
  assign rsp_o.data  = out_q;
endmodule
`default_nettype wire

// ----- rtl/core/f8m_checker.sv -----
`default_nettype none
`include "fp8_e4m3_multiply_assert.svh"
module f8m_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_data_i
);
  `ASSERT_NEXT(hold_valid, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(hold_data, out_valid_i && !out_ready_i, $stable(out_data_i))
  `ASSERT_IMPL(ready_when_free, !out_valid_i, in_ready_i)
  `ASSERT_IMPL(nan_negative_free, out_valid_i, out_data_i != 8'hFF)
endmodule

bind fp8_e4m3_multiply f8m_checker u_f8m_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(req_i.valid), .in_ready_i(req_i.ready),
  .out_valid_i(rsp_o.valid), .out_ready_i(rsp_o.ready), .out_data_i(rsp_o.data)
);
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import f8m_pkg::*;

  logic clk_i;
  logic rst_ni;
  f8m_stream_if #(.Width(16)) req_if ();
  f8m_stream_if #(.Width(8)) rsp_if ();

  fp8_e4m3_multiply uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_i(req_if.sink),
    .rsp_o(rsp_if.source)
  );

  logic [7:0] expected_products[$];
  int errors = 0;
  int cycles = 0;
  bit hold_rsp = 0;
  bit rsp_random = 1;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // behavioral multiply, round to nearest even, saturate, flush
  function automatic logic [7:0] fp8_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] sign;
    int ea, eb, er;
    int fa, fb, prod, mr, sticky, rnd;
    sign = (a ^ b) & SignBit;
    if (a[6:0] == NanCode[6:0] || b[6:0] == NanCode[6:0]) return NanCode;
    if (a[6:0] == 0 || b[6:0] == 0) return sign;
    ea = a[6:3]; fa = a[2:0];
    if (ea == 0) begin
      ea = 1;
      while (fa < 8) begin
        fa = fa << 1;
        ea--;
      end
    end else fa = fa + 8;
    eb = b[6:3]; fb = b[2:0];
    if (eb == 0) begin
      eb = 1;
      while (fb < 8) begin
        fb = fb << 1;
        eb--;
      end
    end else fb = fb + 8;
    prod = fa * fb;
    er = ea + eb - Bias;
    sticky = 0;
    if (prod >= 128) begin
      sticky = prod & 1;
      prod = prod >> 1;
      er++;
    end
    mr = (prod >> 3) & 7;
    rnd = (prod >> 2) & 1;
    if ((prod & 3) != 0) sticky = 1;
    if (rnd != 0 && ((mr & 1) != 0 || sticky != 0)) mr++;
    if (mr > 7) begin
      mr = 0;
      er++;
    end
    if (er > ExpTop || (er == ExpTop && mr == 7)) return sign | MaxMag;
    if (er <= 0) return sign;
    return sign | 8'(er << 3) | 8'(mr);
  endfunction

  // valid stays high after an accept so that back-to-back requests need no gap;
  // an idle gap or a drain drops it
  task automatic send_request(logic [7:0] a, logic [7:0] b, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= {a, b};
    expected_products.push_back(fp8_mul(a, b));
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected product %h", $time, rsp_if.data);
        errors++;
      end else begin
        if (rsp_if.data !== expected_products[0]) begin
          $display("%0t: product expected %h actual %h", $time, expected_products[0],
                   rsp_if.data);
          errors++;
        end
        void'(expected_products.pop_front());
      end
    end
  end

  // receiver stalls
  initial begin
    int wait_cycles;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) rsp_if.ready <= 1'b0;
      else if (!rsp_random) rsp_if.ready <= 1'b1;
      else if (rsp_if.ready && rsp_if.valid) begin
        wait_cycles = $urandom_range(0, 9);
        if (wait_cycles != 0) begin
          rsp_if.ready <= 1'b0;
          repeat (wait_cycles) @(posedge clk_i);
        end
        rsp_if.ready <= 1'b1;
      end else rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    @(posedge clk_i);
    while (cycles < 400000) @(posedge clk_i) cycles++;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic test_special_cases();
    logic [7:0] codes[12];
    codes = '{8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01, 8'h81, 8'h07, 8'h08,
              8'h7E, 8'hFE, 8'h38, 8'h77};
    for (int i = 0; i < 12; i++) send_request(codes[i], codes[(i * 5 + 3) % 12]);
    send_request(8'h7E, 8'h7E);
    send_request(8'h01, 8'h01);
    send_request(8'h7F, 8'h00);
    send_request(8'h78, 8'h38);
    send_request(8'h3C, 8'h3C);
    send_request(8'h3B, 8'h3D);
    wait_drained();
  endtask

  task automatic test_random_products(int count);
    for (int i = 0; i < count; i++)
      send_request(8'($urandom), 8'($urandom), (i % 100) > 80);
  endtask

  task automatic test_back_pressure();
    hold_rsp = 1;
    fork
      for (int i = 0; i < 20; i++) send_request(8'($urandom), 8'($urandom), 1);
      repeat (60) @(posedge clk_i);
    join_any
    hold_rsp = 0;
    wait fork;
    wait_drained();
  endtask

  task automatic test_full_rate();
    rsp_random = 0;
    for (int i = 0; i < 50; i++) send_request(8'($urandom), 8'($urandom), 1);
    wait_drained();
    rsp_random = 1;
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_random_products(300);
    test_back_pressure();
    test_full_rate();
    test_random_products(250);
    wait_drained();
    if (errors == 0 && expected_products.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
